// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/sshdf_pkg.sv
// ----------------------------------------------------------------------------
// sshdf_pkg
// Constants and types for the SSH packet deframer.
// ----------------------------------------------------------------------------
package sshdf_pkg;

  // Width of the packet length and body counters (16..32)
  localparam int unsigned LENGTH_BITS = 20;
  // Extra bytes allowed above the configured maximum packet length
  localparam int unsigned OVERHEAD    = 32;
  // Number of big-endian packet length bytes
  localparam int unsigned LEN_BYTES   = 4;

  localparam int unsigned MAXLEN_W    = 20;
  localparam int unsigned PLEN_W      = 20;
  localparam int unsigned HCNT_W      = $clog2(LEN_BYTES + 1);
  localparam int unsigned MAX_RESET   = 35032;

  // Largest length the counters can represent, held in 33 bits
  localparam logic [32:0] LEN_LIMIT = 33'((64'd1 << LENGTH_BITS) - 64'd1);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_ERROR  = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    K_HEADER  = 3'd0,
    K_TYPE    = 3'd1,
    K_PAYLOAD = 3'd2,
    K_PADDING = 3'd3,
    K_ERROR   = 3'd4
  } kind_e;

endpackage

// File: rtl/ssh_packet_deframer.sv
// A result appears in the output register in the cycle after its byte is taken.
// Throughput: one byte per clock; the single result register is drained and
// refilled in the same cycle, so input stalls only while that register is held.
// Reset: deframer returns to the header phase with empty counters, the error
// flag clears and the max packet length register returns to 35032.
// ----------------------------------------------------------------------------
// ssh_packet_deframer
// Classifies decrypted SSH transport bytes as header, message type, payload
// or padding, marks the last byte of each packet and flags bad lengths.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssh_packet_deframer import sshdf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [MAXLEN_W-1:0] cfg_max_packet_length_i,
  // byte input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  // classified output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic [2:0]          kind_o,
  output logic                last_o,
  output logic [PLEN_W-1:0]   payload_length_o
);

  localparam int unsigned LB = LENGTH_BITS;

  // Registers
  logic [MAXLEN_W-1:0] max_len_q;
  phase_e              phase_q, phase_d;
  logic [HCNT_W-1:0]   hdr_cnt_q, hdr_cnt_d;
  logic [31:0]         len_q, len_d;
  logic [LB-1:0]       body_cnt_q, body_cnt_d;
  logic [LB-1:0]       plen_q, plen_d;       // payload length incl. message byte
  logic [LB-1:0]       last_idx_q, last_idx_d; // index of final body byte
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q;
  kind_e               kind_q, kind_d;
  logic                last_q, last_d;
  logic [PLEN_W-1:0]   out_plen_q, out_plen_d;

  logic        accept;
  logic [31:0] len_shift;
  logic [32:0] len_cap;
  logic        too_long;
  logic        too_short;
  logic [LB-1:0] plen_new;
  logic [31:0] plen_new_ext;
  logic [31:0] plen_q_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  // Header arithmetic
  assign len_shift = {len_q[23:0], data_byte_i};
  assign len_cap   = {{(33-MAXLEN_W){1'b0}}, max_len_q} + 33'(OVERHEAD);
  assign too_long  = ({1'b0, len_shift} > len_cap) || ({1'b0, len_shift} > LEN_LIMIT);
  assign too_short = {1'b0, len_q} < (33'(data_byte_i) + 33'd2);
  assign plen_new  = LB'(len_q) - LB'(1) - LB'(data_byte_i);
  assign plen_new_ext = 32'(plen_new);
  assign plen_q_ext   = 32'(plen_q);

  // Next-state and result classification
  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    len_d      = len_q;
    body_cnt_d = body_cnt_q;
    plen_d     = plen_q;
    last_idx_d = last_idx_q;
    kind_d     = K_ERROR;
    last_d     = 1'b0;
    out_plen_d = '0;

    case (phase_q)
      PH_HEADER: begin
        if (hdr_cnt_q < HCNT_W'(LEN_BYTES)) begin
          len_d     = len_shift;
          hdr_cnt_d = hdr_cnt_q + HCNT_W'(1);
          kind_d    = K_HEADER;
          if (hdr_cnt_q == HCNT_W'(LEN_BYTES - 1) && too_long) begin
            phase_d = PH_ERROR;
            kind_d  = K_ERROR;
          end
        end else if (too_short) begin
          phase_d = PH_ERROR;
        end else begin
          // padding-length byte
          phase_d    = PH_BODY;
          body_cnt_d = '0;
          plen_d     = plen_new;
          last_idx_d = LB'(len_q) - LB'(2);
          kind_d     = K_HEADER;
          out_plen_d = plen_new_ext[PLEN_W-1:0];
        end
      end
      PH_BODY: begin
        out_plen_d = plen_q_ext[PLEN_W-1:0];
        if (body_cnt_q == '0) begin
          kind_d = K_TYPE;
        end else if (body_cnt_q < plen_q) begin
          kind_d = K_PAYLOAD;
        end else begin
          kind_d = K_PADDING;
        end
        if (body_cnt_q >= last_idx_q) begin
          last_d     = 1'b1;
          phase_d    = PH_HEADER;
          hdr_cnt_d  = '0;
          len_d      = '0;
          body_cnt_d = '0;
        end else begin
          body_cnt_d = body_cnt_q + LB'(1);
        end
      end
      default: begin
        kind_d = K_ERROR;
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MAXLEN_W'(MAX_RESET);
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= '0;
      len_q       <= '0;
      body_cnt_q  <= '0;
      plen_q      <= '0;
      last_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_max_packet_length_i;
      end
      if (accept) begin
        phase_q    <= phase_d;
        hdr_cnt_q  <= hdr_cnt_d;
        len_q      <= len_d;
        body_cnt_q <= body_cnt_d;
        plen_q     <= plen_d;
        last_idx_q <= last_idx_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_byte_q <= data_byte_i;
      kind_q     <= kind_d;
      last_q     <= last_d;
      out_plen_q <= out_plen_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign kind_o           = kind_q;
  assign last_o           = last_q;
  assign payload_length_o = out_plen_q;

  // Assertions
  `ASSERT_NEXT(a_error_sticky, clk_i, rst_ni, phase_q == PH_ERROR, phase_q == PH_ERROR)
  `ASSERT_IMPLIES(a_last_is_body, clk_i, rst_ni, out_valid_q && last_q,
                  kind_q == K_TYPE || kind_q == K_PAYLOAD || kind_q == K_PADDING)
  `ASSERT_IMPLIES(a_error_clean, clk_i, rst_ni, out_valid_q && kind_q == K_ERROR,
                  !last_q && out_plen_q == '0)
  `ASSERT_IMPLIES(a_body_in_range, clk_i, rst_ni, phase_q == PH_BODY,
                  body_cnt_q <= last_idx_q && plen_q != '0)

endmodule

// File: bench/ssh_packet_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_packet_deframer_tb
// Feeds framed SSH transport bytes through the deframer: small packets under
// several packet length limits, boundary lengths and paddings, and one bad
// length at the end. An in-bench model predicts the class of every byte, and
// the result stream is compared field by field with the predictions.
// ----------------------------------------------------------------------------
module ssh_packet_deframer_tb;
  import sshdf_pkg::*;

  // One classified byte
  typedef struct packed {
    logic [7:0]        data;
    kind_e             kind;
    logic              last;
    logic [PLEN_W-1:0] plen;
  } byte_class_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [MAXLEN_W-1:0] cfg_max_packet_length_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          data_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          out_byte_o;
  logic [2:0]          kind_o;
  logic                last_o;
  logic [PLEN_W-1:0]   payload_length_o;

  ssh_packet_deframer uut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_max_packet_length_i (cfg_max_packet_length_i),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .data_byte_i             (data_byte_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .out_byte_o              (out_byte_o),
    .kind_o                  (kind_o),
    .last_o                  (last_o),
    .payload_length_o        (payload_length_o)
  );

  always #5 clk_i = ~clk_i;

  // Bytes waiting to be sent, and predicted classes waiting to come out
  logic [7:0]  rx_bytes_q[$];
  byte_class_t byte_class_q[$];
  int          queued_cnt = 0;
  int          taken_cnt = 0;
  int          mismatch_cnt = 0;

  // Deframer model state
  phase_e                 df_phase;
  logic [2:0]             df_hdr_cnt;
  logic [31:0]            df_len_word;
  logic [7:0]             df_pad_len;
  logic [LENGTH_BITS-1:0] df_body_idx;
  logic [MAXLEN_W-1:0]    df_max_len;

  // Append one byte to the send queue
  function automatic void enqueue_byte(logic [7:0] b);
    rx_bytes_q.insert(rx_bytes_q.size(), b);
  endfunction

  function automatic void clear_packet();
    df_phase    = PH_HEADER;
    df_hdr_cnt  = '0;
    df_len_word = '0;
    df_pad_len  = '0;
    df_body_idx = '0;
  endfunction

  // Advance the model by one byte and return its class
  function automatic byte_class_t classify_byte(logic [7:0] b);
    byte_class_t       r;
    longint unsigned   len;
    longint unsigned   body_len;
    longint unsigned   plen;
    r.data = b;
    r.kind = K_ERROR;
    r.last = 1'b0;
    plen   = 0;
    if (df_phase == PH_HEADER) begin
      if (df_hdr_cnt < LEN_BYTES) begin
        df_len_word = {df_len_word[23:0], b};
        df_hdr_cnt  = df_hdr_cnt + 3'd1;
        r.kind      = K_HEADER;
        len         = df_len_word;
        if (df_hdr_cnt == LEN_BYTES &&
            (len > longint'(df_max_len) + OVERHEAD || len > LEN_LIMIT)) begin
          df_phase = PH_ERROR;
          r.kind   = K_ERROR;
        end
      end else begin
        len = df_len_word;
        // padding length byte: packet must hold itself, the type and padding
        if (len < longint'(b) + 2) begin
          df_phase = PH_ERROR;
        end else begin
          df_pad_len  = b;
          df_body_idx = '0;
          df_phase    = PH_BODY;
          r.kind      = K_HEADER;
          plen        = len - 1 - b;
        end
      end
    end else if (df_phase == PH_BODY) begin
      body_len = longint'(df_len_word) - 1;
      plen     = body_len - df_pad_len;
      if (df_body_idx == 0) r.kind = K_TYPE;
      else if (longint'(df_body_idx) < plen) r.kind = K_PAYLOAD;
      else r.kind = K_PADDING;
      if (longint'(df_body_idx) + 1 >= body_len) begin
        r.last = 1'b1;
        clear_packet();
      end else begin
        df_body_idx = df_body_idx + 1'b1;
      end
    end
    r.plen = plen[PLEN_W-1:0];
    return r;
  endfunction

  // No idling while this window of requests goes through
  function automatic logic no_idle_window();
    return taken_cnt >= 700 && taken_cnt < 1000;
  endfunction

  // Byte driver: a request holds until taken, then the next one is offered
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        byte_class_q.insert(byte_class_q.size(), classify_byte(data_byte_i));
        taken_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rx_bytes_q.size() > 0 && (no_idle_window() || $urandom_range(99) >= 6)) begin
          in_valid_i  <= 1'b1;
          data_byte_i <= rx_bytes_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    byte_class_t exp_c;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (byte_class_q.size() == 0) begin
          $error("unexpected result: out_byte %0h kind %0d", out_byte_o, kind_o);
          mismatch_cnt++;
        end else begin
          exp_c = byte_class_q.pop_front();
          if (out_byte_o !== exp_c.data) begin
            $error("out_byte: expected %0h, got %0h", exp_c.data, out_byte_o);
            mismatch_cnt++;
          end
          if (kind_o !== exp_c.kind) begin
            $error("kind: expected %0d, got %0d", exp_c.kind, kind_o);
            mismatch_cnt++;
          end
          if (last_o !== exp_c.last) begin
            $error("last: expected %0b, got %0b", exp_c.last, last_o);
            mismatch_cnt++;
          end
          if (payload_length_o !== exp_c.plen) begin
            $error("payload_length: expected %0d, got %0d", exp_c.plen, payload_length_o);
            mismatch_cnt++;
          end
        end
      end
      // one long hold so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && taken_cnt >= 300) begin
        hold_done = 1'b1;
        hold_left = 60;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_idle_window() && $urandom_range(99) < 6;
      end
    end
  end

  // Length header, padding byte and optionally random body bytes
  task automatic queue_packet(input int unsigned len, input int unsigned pad,
                              input bit with_body);
    for (int i = 3; i >= 0; i--) enqueue_byte(8'(len >> (8 * i)));
    enqueue_byte(8'(pad));
    queued_cnt += 5;
    if (with_body) begin
      for (int unsigned i = 1; i < len; i++) enqueue_byte(8'($urandom));
      queued_cnt += len - 1;
    end
  endtask

  // Well-formed packet no longer than cap, mostly short
  task automatic queue_random_packet(input int unsigned cap);
    int unsigned len;
    int unsigned pad;
    int unsigned pad_cap;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 75) len = $urandom_range(cap < 40 ? cap : 40, 2);
    else if (sel < 95) len = $urandom_range(cap < 300 ? cap : 300, 2);
    else len = cap < 600 ? cap : 600;
    pad_cap = len - 2 < 255 ? len - 2 : 255;
    sel = $urandom_range(3);
    if (sel == 0) pad = pad_cap;
    else if (sel == 1) pad = $urandom_range(pad_cap, 0);
    else pad = $urandom_range(pad_cap < 16 ? pad_cap : 16, 0);
    queue_packet(len, pad, 1'b1);
  endtask

  task automatic fill_random(input int unsigned target, input int unsigned cap);
    while (queued_cnt < target) queue_random_packet(cap);
  endtask

  // Wait until every request is taken and every result has come out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (rx_bytes_q.size() > 0 || in_valid_i || byte_class_q.size() > 0);
  endtask

  task automatic write_max_len(input logic [MAXLEN_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i             <= 1'b1;
    cfg_max_packet_length_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    df_max_len  = value;
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    int unsigned max_len;
    int unsigned pad;
    df_max_len = MAXLEN_W'(MAX_RESET);
    clear_packet();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // shortest packet, type byte only after padding, all-zero/all-one bytes
    queue_packet(2, 0, 1'b1);
    queue_packet(3, 1, 1'b1);
    enqueue_byte(8'h00);
    enqueue_byte(8'h00);
    enqueue_byte(8'h00);
    enqueue_byte(8'h05);
    enqueue_byte(8'h00);
    enqueue_byte(8'hFF);
    enqueue_byte(8'h00);
    enqueue_byte(8'hFF);
    enqueue_byte(8'hAA);
    queued_cnt += 9;
    // largest padding length
    queue_packet(257, 255, 1'b1);
    fill_random(420, MAX_RESET + OVERHEAD);

    // smallest limit, and a packet exactly at it
    wait_drained();
    write_max_len('0);
    queue_packet(OVERHEAD, $urandom_range(OVERHEAD - 2, 0), 1'b1);
    fill_random(820, OVERHEAD);

    // largest limit
    wait_drained();
    write_max_len({MAXLEN_W{1'b1}});
    fill_random(1270, 600);

    // random limit
    wait_drained();
    max_len = $urandom_range(400, 0);
    write_max_len(MAXLEN_W'(max_len));
    fill_random(1690, max_len + OVERHEAD);

    // one bad length, then bytes that stay in error
    wait_drained();
    case ($urandom_range(2))
      0: queue_packet(df_max_len + OVERHEAD + 1, 0, 1'b0);
      1: begin
        write_max_len({MAXLEN_W{1'b1}});
        queue_packet(32'(LEN_LIMIT) + 32'd1, 0, 1'b0);
      end
      default: begin
        pad = $urandom_range(255);
        queue_packet($urandom_range(pad + 1, 0), pad, 1'b0);
      end
    endcase
    repeat (50) enqueue_byte(8'($urandom));

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(2_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: ssh_packet_deframer.f
+incdir+rtl
rtl/sshdf_pkg.sv
rtl/ssh_packet_deframer.sv
bench/ssh_packet_deframer_tb.sv
